@@ sv/cscan_disk_scheduler_core_macros.svh @@
// ============================================================================
// C-SCAN disk scheduler assertion macros
// Shared property shorthands for the scheduler's checker.
// ============================================================================
`ifndef CSCAN_DISK_SCHEDULER_CORE_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_CORE_MACROS_SVH

// Implication that must hold in the same cycle, outside reset.
`define CSCAN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent must hold in the next cycle, outside reset.
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cscan_pkg.sv @@
// ============================================================================
// C-SCAN disk scheduler package
// Word types, register indexes, constants and sequencer states.
// ============================================================================
package cscan_pkg;

    // Default batch capacity of the request store.
    localparam int MAX_REQUESTS_DEF = 16;

    // Field widths.
    localparam int CYL_W  = 16;
    localparam int MOVE_W = 24;
    localparam int CFG_IDX_W = 2;

    // Saturation limit of the movement total.
    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LEFT = 2'd2;

    // Configuration reset values.
    localparam logic [CYL_W-1:0] DISK_SIZE_RST  = 16'd200;
    localparam logic [CYL_W-1:0] HEAD_START_RST = 16'd50;
    localparam logic             SWEEP_LEFT_RST = 1'b0;

    // One request word.
    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             batch_end;
    } req_word_t;

    // One result word.
    typedef struct packed {
        logic [CYL_W-1:0]  served_cylinder;
        logic [MOVE_W-1:0] movement_so_far;
        logic              final_served;
    } rsp_word_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_START,
        ST_SPLIT_CHK,
        ST_SPLIT_CMP,
        ST_SRV_RD,
        ST_SRV_DIST,
        ST_SRV_ADD,
        ST_SRV_EMIT,
        ST_EDGE_DIST,
        ST_EDGE_ADD
    } state_t;

endpackage

@@ sv/cscan_disk_scheduler_core.sv @@
// Loading: a word is taken in the idle state; insertion into the sorted store then
// reads each larger entry and shifts it up one place before the word is written in.
// Scheduling: a setup step, a split search comparing entries with the head, then
// read, distance, add and emit steps per result, an edge move, and a check at the end
// of each sweep direction; emit waits on rsp_stall. req_stall is high outside ST_IDLE.
// Reset clears control, counters and configuration; store contents are undefined.
// ============================================================================
// C-SCAN disk scheduler core
// Keeps a sorted batch of cylinder requests and serves it in C-SCAN order
// through one shared absolute-distance and saturating-add unit.
// ============================================================================
module cscan_disk_scheduler_core #(
    parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cscan_pkg::CYL_W-1:0]         cfg_wdata,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  cscan_pkg::req_word_t                req_word,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output cscan_pkg::rsp_word_t                rsp_word
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CYL_W = cscan_pkg::CYL_W;
    localparam int MOVE_W = cscan_pkg::MOVE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

    // Configuration registers.
    logic [CYL_W-1:0] disk_size_reg;
    logic [CYL_W-1:0] head_start_reg;
    logic             sweep_left_reg;

    // Request store.
    logic [CYL_W-1:0] store_mem [MAX_REQUESTS];
    logic [CYL_W-1:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CYL_W-1:0] wr_data;

    // Sequencer and datapath registers.
    cscan_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ins_pos_reg, ins_pos_next;
    logic [CYL_W-1:0]  new_cyl_reg, new_cyl_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  bound_reg, bound_next;
    logic [CNT_W-1:0]  split_reg, split_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              phase_reg, phase_next;
    logic [CYL_W-1:0]  head_reg, head_next;
    logic [CYL_W-1:0]  dist_reg, dist_next;
    logic [CYL_W-1:0]  cyl_reg, cyl_next;
    logic [MOVE_W-1:0] move_reg, move_next;
    logic              rsp_valid_reg, rsp_valid_next;
    cscan_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    // Shared travel unit: absolute distance and saturating accumulate.
    logic [CYL_W-1:0]  trav_target;
    logic [CYL_W-1:0]  trav_dist;
    logic [MOVE_W:0]   trav_sum;
    logic [MOVE_W-1:0] trav_move;
    logic              rsp_load;

    assign trav_dist = (trav_target > head_reg) ? (trav_target - head_reg)
                                                : (head_reg - trav_target);
    assign trav_sum  = {1'b0, move_reg} + {{(MOVE_W + 1 - CYL_W){1'b0}}, dist_reg};
    assign trav_move = trav_sum[MOVE_W] ? cscan_pkg::MOVE_MAX : trav_sum[MOVE_W-1:0];

    assign rsp_load  = (state_reg == cscan_pkg::ST_SRV_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != cscan_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_size_reg  <= cscan_pkg::DISK_SIZE_RST;
            head_start_reg <= cscan_pkg::HEAD_START_RST;
            sweep_left_reg <= cscan_pkg::SWEEP_LEFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cscan_pkg::REG_DISK_SIZE:  disk_size_reg  <= cfg_wdata;
                cscan_pkg::REG_HEAD_START: head_start_reg <= cfg_wdata;
                cscan_pkg::REG_SWEEP_LEFT: sweep_left_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cscan_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            bound_reg     <= '0;
            split_reg     <= '0;
            remain_reg    <= '0;
            phase_reg     <= 1'b0;
            ins_pos_reg   <= '0;
            last_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            bound_reg     <= bound_next;
            split_reg     <= split_next;
            remain_reg    <= remain_next;
            phase_reg     <= phase_next;
            ins_pos_reg   <= ins_pos_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        new_cyl_reg  <= new_cyl_next;
        head_reg     <= head_next;
        dist_reg     <= dist_next;
        cyl_reg      <= cyl_next;
        move_reg     <= move_next;
        rsp_word_reg <= rsp_word_next;
    end

    // Sequencer: next state, store access and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ins_pos_next   = ins_pos_reg;
        new_cyl_next   = new_cyl_reg;
        last_next      = last_reg;
        ptr_next       = ptr_reg;
        bound_next     = bound_reg;
        split_next     = split_reg;
        remain_next    = remain_reg;
        phase_next     = phase_reg;
        head_next      = head_reg;
        dist_next      = dist_reg;
        cyl_next       = cyl_reg;
        move_next      = move_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = ins_pos_reg[IDX_W-1:0];
        wr_data        = new_cyl_reg;
        trav_target    = rdata_reg;

        // The output register empties when its word is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            cscan_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    new_cyl_next = req_word.request_cylinder;
                    last_next    = req_word.batch_end;
                    ins_pos_next = count_reg;
                    if (count_reg < CNT_MAX)
                    begin
                        state_next = cscan_pkg::ST_INS_CHK;
                    end
                    else if (req_word.batch_end)
                    begin
                        state_next = cscan_pkg::ST_START;
                    end
                end
            end

            // Insertion: shift larger entries up one place, then drop the word in.
            cscan_pkg::ST_INS_CHK:
            begin
                if (ins_pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? cscan_pkg::ST_START : cscan_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr    = IDX_W'(ins_pos_reg - 1'b1);
                    state_next = cscan_pkg::ST_INS_CMP;
                end
            end

            cscan_pkg::ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rdata_reg > new_cyl_reg)
                begin
                    wr_data      = rdata_reg;
                    ins_pos_next = ins_pos_reg - 1'b1;
                    state_next   = cscan_pkg::ST_INS_CHK;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? cscan_pkg::ST_START : cscan_pkg::ST_IDLE;
                end
            end

            // Batch setup from the configuration.
            cscan_pkg::ST_START:
            begin
                head_next   = head_start_reg;
                move_next   = '0;
                ptr_next    = '0;
                remain_next = count_reg;
                state_next  = cscan_pkg::ST_SPLIT_CHK;
            end

            // Split search: first entry at or above the head.
            cscan_pkg::ST_SPLIT_CHK:
            begin
                if (ptr_reg == count_reg)
                begin
                    split_next = ptr_reg;
                    phase_next = 1'b0;
                    bound_next = sweep_left_reg ? '0 : count_reg;
                    state_next = cscan_pkg::ST_SRV_RD;
                end
                else
                begin
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = cscan_pkg::ST_SPLIT_CMP;
                end
            end

            cscan_pkg::ST_SPLIT_CMP:
            begin
                if (rdata_reg < head_reg)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = cscan_pkg::ST_SPLIT_CHK;
                end
                else
                begin
                    split_next = ptr_reg;
                    phase_next = 1'b0;
                    bound_next = sweep_left_reg ? '0 : count_reg;
                    state_next = cscan_pkg::ST_SRV_RD;
                end
            end

            // Sweep: read the next entry of the current phase.
            cscan_pkg::ST_SRV_RD:
            begin
                if (ptr_reg == bound_reg)
                begin
                    if (!phase_reg)
                    begin
                        state_next = cscan_pkg::ST_EDGE_DIST;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = cscan_pkg::ST_IDLE;
                    end
                end
                else if (sweep_left_reg)
                begin
                    rd_addr    = IDX_W'(ptr_reg - 1'b1);
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = cscan_pkg::ST_SRV_DIST;
                end
                else
                begin
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = cscan_pkg::ST_SRV_DIST;
                end
            end

            cscan_pkg::ST_SRV_DIST:
            begin
                dist_next  = trav_dist;
                head_next  = rdata_reg;
                cyl_next   = rdata_reg;
                state_next = cscan_pkg::ST_SRV_ADD;
            end

            cscan_pkg::ST_SRV_ADD:
            begin
                move_next  = trav_move;
                state_next = cscan_pkg::ST_SRV_EMIT;
            end

            cscan_pkg::ST_SRV_EMIT:
            begin
                if (rsp_load)
                begin
                    rsp_word_next.served_cylinder = cyl_reg;
                    rsp_word_next.movement_so_far = move_reg;
                    rsp_word_next.final_served    = (remain_reg == CNT_W'(1));
                    rsp_valid_next = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    state_next     = cscan_pkg::ST_SRV_RD;
                end
            end

            // Edge move to the disk end, then jump to the far side.
            cscan_pkg::ST_EDGE_DIST:
            begin
                trav_target = sweep_left_reg ? '0 : disk_size_reg;
                dist_next   = trav_dist;
                state_next  = cscan_pkg::ST_EDGE_ADD;
            end

            cscan_pkg::ST_EDGE_ADD:
            begin
                move_next  = trav_move;
                head_next  = sweep_left_reg ? disk_size_reg : '0;
                phase_next = 1'b1;
                ptr_next   = sweep_left_reg ? count_reg : '0;
                bound_next = split_reg;
                state_next = cscan_pkg::ST_SRV_RD;
            end

            default:
            begin
                state_next = cscan_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/cscan_disk_scheduler_core_chk.sv @@
// ============================================================================
// C-SCAN disk scheduler port checker
// Watches the scheduler's request and result channels over time.
// ============================================================================
`include "cscan_disk_scheduler_core_macros.svh"

module cscan_disk_scheduler_core_chk (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input cscan_pkg::req_word_t req_word,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input cscan_pkg::rsp_word_t rsp_word
);

    // A stalled result word stays offered and unchanged.
    `CSCAN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result word changed while stalled")

    // Closing a batch always makes the block busy in the next cycle.
    `CSCAN_ASSERT_NEXT(a_batch_busy, req_valid && !req_stall && req_word.batch_end, req_stall, "block not busy after batch end")

    // A fresh result only appears out of a busy cycle.
    `CSCAN_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result appeared while idle")

endmodule

bind cscan_disk_scheduler_core cscan_disk_scheduler_core_chk u_cscan_chk (.*);
